// ===== hw/rtl/csv_column_aligner_defines.svh =====
// Assertion helpers used by the checker file.
// Both expect aclk and aresetn to be visible where they are used.
`ifndef CSV_COLUMN_ALIGNER_DEFINES_SVH
`define CSV_COLUMN_ALIGNER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CSVCA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CSVCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/csvca_pkg.sv =====
package csvca_pkg;

    localparam int MAX_WIDTH   = 30;
    localparam int ROW_BITS    = 16;
    localparam int CW_BITS     = 5;
    localparam int BYTE_W      = 8;
    localparam int ROWNUM_W    = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = BYTE_W + ROWNUM_W;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CW_BITS-1:0] MAX_W = CW_BITS'(MAX_WIDTH);

    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_QUOTE   = 8'h22;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_WIDTH   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_CHAR       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHOW_ROW_INDEX = 8'd2;

    localparam logic [CW_BITS-1:0] COLUMN_WIDTH_RESET = 5'd10;
    localparam logic [BYTE_W-1:0]  PAD_CHAR_RESET     = 8'd32;
    localparam logic               SHOW_ROW_RESET     = 1'b1;

    typedef enum logic [1:0] {
        EMIT_PAD,
        EMIT_BYTE,
        EMIT_NEWLINE,
        EMIT_TOKEN
    } emit_kind_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        emit_kind_t kind;
        logic       last;
        logic       gap_inc;
        logic       toggle_quote;
        logic       row_advance;
        logic       cell_inc;
        logic       cell_clr;
        logic       clear_stream;
    } csvca_cmd_t;

    typedef struct packed {
        logic eoi;
        logic is_newline;
        logic comma_unq;
        logic is_quote;
        logic cell_le_w;
        logic cell_ne_w;
        logic gap_done;
        logic main_emits;
        logic gap_needed;
        logic show;
        logic out_free;
    } csvca_status_t;

endpackage

// ===== hw/rtl/csv_column_aligner.sv =====
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    tdata: in_byte; tlast: end_of_input
// m_        out  m_tvalid/m_tready    tdata: out_byte, row_number; tuser: is_row_token;
//                                     tlast: last_of_run
// cfg_      in   cfg_valid/cfg_ready  cfg_index selects register, cfg_data holds value
//
// One item at a time: a byte is accepted only while the control sequencer is idle,
// and it returns there once that byte's results are issued. With row index shown,
// the first byte of a stream adds width+1 gap pads; an unquoted comma adds width+1-cell
// pads (none once the cell is past the width); a newline with row index adds a row
// token. Each result leaves through one output register; a stall on m_tready holds
// the sequencer. aresetn is synchronous, active low; cfg_ready is always high.
module csv_column_aligner (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [csvca_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] in_byte
    input  logic                                s_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [csvca_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [7:0] out_byte, [23:8] row_number
    output logic                                m_tuser,   // [0] is_row_token
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [csvca_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [csvca_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import csvca_pkg::*;

    csvca_cmd_t    cmd;
    csvca_status_t st;

    assign cfg_ready = 1'b1;

    csvca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    csvca_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

// ===== hw/rtl/csvca_ctrl.sv =====
module csvca_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  csvca_pkg::csvca_status_t st,
    output csvca_pkg::csvca_cmd_t    cmd
);
    import csvca_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAP,
        ST_MAIN,
        ST_PAD,
        ST_TOKEN
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.kind   = EMIT_PAD;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = st.gap_needed ? ST_GAP : ST_MAIN;
                end
            end
            ST_GAP: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = EMIT_PAD;
                    // the gap closes the run only when the byte itself yields nothing
                    cmd.last = st.gap_done && !st.main_emits;
                    if (st.gap_done) begin
                        state_next = ST_MAIN;
                    end else begin
                        cmd.gap_inc = 1'b1;
                    end
                end
            end
            ST_MAIN: begin
                if (st.out_free) begin
                    state_next = ST_IDLE;
                    if (st.eoi) begin
                        cmd.emit         = 1'b1;
                        cmd.kind         = EMIT_NEWLINE;
                        cmd.last         = 1'b1;
                        cmd.clear_stream = 1'b1;
                    end else if (st.is_newline) begin
                        cmd.emit        = 1'b1;
                        cmd.kind        = EMIT_NEWLINE;
                        cmd.last        = !st.show;
                        cmd.row_advance = 1'b1;
                        if (st.show) begin
                            state_next = ST_TOKEN;
                        end
                    end else if (st.comma_unq) begin
                        if (st.cell_le_w) begin
                            state_next = ST_PAD;
                        end else begin
                            cmd.cell_clr = 1'b1;
                        end
                    end else begin
                        cmd.toggle_quote = st.is_quote;
                        if (st.cell_ne_w) begin
                            cmd.emit     = 1'b1;
                            cmd.kind     = EMIT_BYTE;
                            cmd.last     = 1'b1;
                            cmd.cell_inc = 1'b1;
                        end
                    end
                end
            end
            ST_PAD: begin
                if (st.out_free) begin
                    cmd.emit = 1'b1;
                    cmd.kind = EMIT_PAD;
                    // cell == width means this pad fills position width+1
                    cmd.last = !st.cell_ne_w;
                    if (!st.cell_ne_w) begin
                        cmd.cell_clr = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        cmd.cell_inc = 1'b1;
                    end
                end
            end
            ST_TOKEN: begin
                if (st.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = EMIT_TOKEN;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/csvca_datapath.sv =====
module csvca_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic [csvca_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [csvca_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                  m_tuser,
    output logic                                  m_tlast,
    input  logic                                  cfg_valid,
    input  logic [csvca_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csvca_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  csvca_pkg::csvca_cmd_t                 cmd,
    output csvca_pkg::csvca_status_t              st
);
    import csvca_pkg::*;

    logic [CW_BITS-1:0]  column_width_reg;
    logic [BYTE_W-1:0]   pad_char_reg;
    logic                show_row_reg;

    logic [BYTE_W-1:0]   in_byte_reg;
    logic                eoi_reg;
    logic                started_reg, started_next;
    logic                in_quotes_reg, in_quotes_next;
    logic [CW_BITS-1:0]  cell_len_reg, cell_len_next;
    logic [ROW_BITS-1:0] rows_done_reg, rows_done_next;
    logic [CW_BITS-1:0]  gap_cnt_reg, gap_cnt_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;
    logic                   out_user_reg, out_user_next;
    logic                   out_last_reg, out_last_next;

    logic [CW_BITS-1:0] w;
    logic               is_newline, is_comma, is_quote, comma_unq, cell_le_w, cell_ne_w;

    assign w          = (column_width_reg > MAX_W) ? MAX_W : column_width_reg;
    assign is_newline = (in_byte_reg == CH_NEWLINE);
    assign is_comma   = (in_byte_reg == CH_COMMA);
    assign is_quote   = (in_byte_reg == CH_QUOTE);
    assign comma_unq  = is_comma && !in_quotes_reg;
    assign cell_le_w  = (cell_len_reg <= w);
    assign cell_ne_w  = (cell_len_reg != w);

    always_comb begin
        st            = '0;
        st.eoi        = eoi_reg;
        st.is_newline = is_newline;
        st.comma_unq  = comma_unq;
        st.is_quote   = is_quote;
        st.cell_le_w  = cell_le_w;
        st.cell_ne_w  = cell_ne_w;
        st.gap_done   = (gap_cnt_reg == w);
        st.main_emits = eoi_reg || is_newline || (comma_unq ? cell_le_w : cell_ne_w);
        st.gap_needed = !s_tlast && !started_reg && show_row_reg;
        st.show       = show_row_reg;
        st.out_free   = !out_valid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_width_reg <= COLUMN_WIDTH_RESET;
            pad_char_reg     <= PAD_CHAR_RESET;
            show_row_reg     <= SHOW_ROW_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_COLUMN_WIDTH:   column_width_reg <= cfg_data[CW_BITS-1:0];
                REG_PAD_CHAR:       pad_char_reg     <= cfg_data[BYTE_W-1:0];
                REG_SHOW_ROW_INDEX: show_row_reg     <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_comb begin
        started_next   = started_reg;
        in_quotes_next = in_quotes_reg;
        cell_len_next  = cell_len_reg;
        rows_done_next = rows_done_reg;
        gap_cnt_next   = gap_cnt_reg;
        if (cmd.load) begin
            gap_cnt_next = '0;
            started_next = started_reg || !s_tlast;
        end
        if (cmd.gap_inc) begin
            gap_cnt_next = gap_cnt_reg + 1'b1;
        end
        if (cmd.toggle_quote) begin
            in_quotes_next = !in_quotes_reg;
        end
        if (cmd.cell_inc && (cell_len_reg != '1)) begin
            cell_len_next = cell_len_reg + 1'b1;
        end
        if (cmd.cell_clr) begin
            cell_len_next = '0;
        end
        if (cmd.row_advance) begin
            rows_done_next = rows_done_reg + 1'b1;
            cell_len_next  = '0;
            in_quotes_next = 1'b0;
        end
        if (cmd.clear_stream) begin
            started_next   = 1'b0;
            in_quotes_next = 1'b0;
            cell_len_next  = '0;
            rows_done_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg   <= 1'b0;
            in_quotes_reg <= 1'b0;
            cell_len_reg  <= '0;
            rows_done_reg <= '0;
        end else begin
            started_reg   <= started_next;
            in_quotes_reg <= in_quotes_next;
            cell_len_reg  <= cell_len_next;
            rows_done_reg <= rows_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        gap_cnt_reg <= gap_cnt_next;
        if (cmd.load) begin
            in_byte_reg <= s_tdata[BYTE_W-1:0];
            eoi_reg     <= s_tlast;
        end
    end

    // output register: hold until taken, reload on emit
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            out_user_next  = (cmd.kind == EMIT_TOKEN);
            out_last_next  = cmd.last;
            case (cmd.kind)
                EMIT_PAD:     out_data_next = {{ROWNUM_W{1'b0}}, pad_char_reg};
                EMIT_BYTE:    out_data_next = {{ROWNUM_W{1'b0}}, in_byte_reg};
                EMIT_NEWLINE: out_data_next = {{ROWNUM_W{1'b0}}, CH_NEWLINE};
                EMIT_TOKEN:   out_data_next = {ROWNUM_W'(rows_done_reg), {BYTE_W{1'b0}}};
                default:      out_data_next = '0;
            endcase
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/csvca_checker.sv =====
`include "csv_column_aligner_defines.svh"

module csvca_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [csvca_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input logic                                m_tuser,
    input logic                                m_tlast
);
    import csvca_pkg::*;

    // a stalled result must not change
    `CSVCA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "result changed while stalled")

    // a row token always closes the run of its newline
    `CSVCA_ASSERT_SAME(a_token_last, m_tvalid && m_tuser, m_tlast,
        "row token not marked last")

    `CSVCA_ASSERT_SAME(a_token_byte_zero, m_tvalid && m_tuser,
        m_tdata[BYTE_W-1:0] == '0, "row token carries a byte")

    `CSVCA_ASSERT_SAME(a_char_row_zero, m_tvalid && !m_tuser,
        m_tdata[OUT_TDATA_W-1:BYTE_W] == '0, "character carries a row number")

endmodule

bind csv_column_aligner csvca_checker u_csvca_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
    import csvca_pkg::*;

    localparam int SETTLE_CYCLES = 10;
    localparam int QUIET_LIMIT   = 1000;

    // one aligned output item
    typedef struct packed {
        logic [7:0]  ch;
        logic        tok;
        logic [15:0] row;
        logic        last;
    } col_item_t;

    // one stimulus row: optional register update, the input item, and, where typed,
    // the expected output as (n_res - 1) lead bytes followed by one final item
    typedef struct packed {
        logic        reconf;
        logic [4:0]  cw;
        logic [7:0]  pc;
        logic        sri;
        logic [7:0]  data;
        logic        eoi;
        logic        typed;
        logic [6:0]  n_res;
        logic [7:0]  lead;
        logic [7:0]  fin;
        logic        tok;
        logic [15:0] rnum;
    } step_t;

    localparam step_t DIRECTED [0:23] = '{
        '{0, 5'd0,  8'h00, 0, 8'h41,      0, 1, 7'd12, 8'h20,      8'h41,      0, 16'd0},
        '{0, 5'd0,  8'h00, 0, 8'hFF,      0, 1, 7'd1,  8'h00,      8'hFF,      0, 16'd0},
        '{0, 5'd0,  8'h00, 0, 8'h00,      0, 1, 7'd1,  8'h00,      8'h00,      0, 16'd0},
        '{0, 5'd0,  8'h00, 0, CH_COMMA,   0, 1, 7'd8,  8'h20,      8'h20,      0, 16'd0},
        '{0, 5'd0,  8'h00, 0, CH_QUOTE,   0, 1, 7'd1,  8'h00,      CH_QUOTE,   0, 16'd0},
        '{0, 5'd0,  8'h00, 0, CH_COMMA,   0, 1, 7'd1,  8'h00,      CH_COMMA,   0, 16'd0},
        '{0, 5'd0,  8'h00, 0, CH_NEWLINE, 0, 1, 7'd2,  CH_NEWLINE, 8'h00,      1, 16'd1},
        '{0, 5'd0,  8'h00, 0, CH_COMMA,   0, 1, 7'd11, 8'h20,      8'h20,      0, 16'd0},
        '{0, 5'd0,  8'h00, 0, 8'h78,      0, 0, 7'd0,  8'h00,      8'h00,      0, 16'd0},
        '{0, 5'd0,  8'h00, 0, 8'hFF,      1, 1, 7'd1,  8'h00,      CH_NEWLINE, 0, 16'd0},
        // zero width, zero pad, no row index
        '{1, 5'd0,  8'h00, 0, 8'h71,      0, 1, 7'd0,  8'h00,      8'h00,      0, 16'd0},
        '{0, 5'd0,  8'h00, 0, CH_COMMA,   0, 1, 7'd1,  8'h00,      8'h00,      0, 16'd0},
        '{0, 5'd0,  8'h00, 0, CH_NEWLINE, 0, 1, 7'd1,  8'h00,      CH_NEWLINE, 0, 16'd0},
        '{0, 5'd0,  8'h00, 0, 8'h00,      1, 1, 7'd1,  8'h00,      CH_NEWLINE, 0, 16'd0},
        // width above the limit: header gap plus a full pad run
        '{1, 5'd31, 8'hFF, 1, CH_COMMA,   0, 1, 7'd62, 8'hFF,      8'hFF,      0, 16'd0},
        '{0, 5'd0,  8'h00, 0, 8'h62,      0, 0, 7'd0,  8'h00,      8'h00,      0, 16'd0},
        '{0, 5'd0,  8'h00, 0, 8'h63,      0, 0, 7'd0,  8'h00,      8'h00,      0, 16'd0},
        '{0, 5'd0,  8'h00, 0, 8'h64,      0, 0, 7'd0,  8'h00,      8'h00,      0, 16'd0},
        // width lowered under an open cell
        '{1, 5'd1,  8'h2E, 1, 8'h65,      0, 1, 7'd1,  8'h00,      8'h65,      0, 16'd0},
        '{0, 5'd0,  8'h00, 0, CH_COMMA,   0, 1, 7'd0,  8'h00,      8'h00,      0, 16'd0},
        '{0, 5'd0,  8'h00, 0, 8'h66,      0, 0, 7'd0,  8'h00,      8'h00,      0, 16'd0},
        '{0, 5'd0,  8'h00, 0, 8'h67,      0, 1, 7'd0,  8'h00,      8'h00,      0, 16'd0},
        '{0, 5'd0,  8'h00, 0, CH_NEWLINE, 0, 1, 7'd2,  CH_NEWLINE, 8'h00,      1, 16'd1},
        '{0, 5'd0,  8'h00, 0, CH_QUOTE,   0, 0, 7'd0,  8'h00,      8'h00,      0, 16'd0}
    };

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [IN_TDATA_W-1:0]      s_tdata   = '0;  // [7:0] in_byte
    logic                       s_tlast   = 1'b0;
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]     m_tdata;         // [7:0] out_byte, [23:8] row_number
    logic                       m_tuser;         // [0] is_row_token
    logic                       m_tlast;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data  = '0;

    // predictor copy of registers and stream state
    logic [4:0]  col_w      = COLUMN_WIDTH_RESET;
    logic [7:0]  pad_b      = PAD_CHAR_RESET;
    logic        show_idx   = SHOW_ROW_RESET;
    logic        seen_first = 1'b0;
    logic        quoted     = 1'b0;
    int          cell_len   = 0;
    logic [15:0] rows_seen  = '0;

    col_item_t   fresh[$];
    col_item_t   pending_out[$];

    bit          send_gaps  = 1'b1;
    bit          sink_gaps  = 1'b1;
    int          items_sent = 0;
    int          results_in = 0;
    int          mismatches = 0;
    int          hold       = 0;
    int          quiet      = 0;

    csv_column_aligner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic void emit(input logic [7:0] c, input logic t, input logic [15:0] r);
        fresh.push_back('{c, t, r, 1'b0});
    endfunction

    // work out the aligned output caused by one input item
    function automatic void align_byte(input logic [7:0] b, input logic eoi);
        int w;
        w = (col_w > MAX_WIDTH) ? MAX_WIDTH : int'(col_w);
        fresh.delete();
        if (eoi) begin
            emit(CH_NEWLINE, 1'b0, 16'd0);
            seen_first = 1'b0;
            quoted     = 1'b0;
            cell_len   = 0;
            rows_seen  = '0;
        end else begin
            if (!seen_first) begin
                if (show_idx)
                    for (int i = 0; i <= w; i++) emit(pad_b, 1'b0, 16'd0);
                seen_first = 1'b1;
            end
            if (b == CH_QUOTE) quoted = !quoted;
            if (b == CH_NEWLINE) begin
                emit(CH_NEWLINE, 1'b0, 16'd0);
                rows_seen = rows_seen + 16'd1;
                cell_len  = 0;
                quoted    = 1'b0;
                if (show_idx) emit(8'h00, 1'b1, rows_seen);
            end else if (b == CH_COMMA && !quoted) begin
                while (cell_len < w + 1) begin
                    emit(pad_b, 1'b0, 16'd0);
                    cell_len++;
                end
                cell_len = 0;
            end else if (cell_len != w) begin
                emit(b, 1'b0, 16'd0);
                if (cell_len < 31) cell_len++;
            end
        end
        if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
    endfunction

    function automatic step_t byte_step(input logic [7:0] b, input logic e);
        step_t s;
        s      = '0;
        s.data = b;
        s.eoi  = e;
        return s;
    endfunction

    task automatic send(input step_t st);
        int gap;
        gap = send_gaps ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= st.data;
        s_tlast  <= st.eoi;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        items_sent++;
        align_byte(st.data, st.eoi);
        if (st.typed) begin
            for (int k = 1; k < st.n_res; k++)
                pending_out.push_back('{st.lead, 1'b0, 16'd0, 1'b0});
            if (st.n_res != 0) pending_out.push_back('{st.fin, st.tok, st.rnum, 1'b1});
        end else begin
            foreach (fresh[k]) pending_out.push_back(fresh[k]);
        end
    endtask

    // hold the sender until every result is out, then let a dropped item settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_out.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [4:0] w, input logic [7:0] pc, input logic sri);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx = '{REG_COLUMN_WIDTH, REG_PAD_CHAR, REG_SHOW_ROW_INDEX};
        // unused upper bits carry noise, the block keeps only the register width
        val = '{{3'($urandom), w}, pc, {7'($urandom), sri}};
        cfg_valid <= 1'b1;
        for (int k = 0; k < 3; k++) begin
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        end
        cfg_valid <= 1'b0;
        col_w    = w;
        pad_b    = pc;
        show_idx = sri;
    endtask

    // mostly well-formed cells and rows with random content, some noise bytes
    task automatic feed_rows(input int count);
        int         stop;
        int         len;
        int         pick;
        logic [7:0] ch;
        bit         q;
        stop = items_sent + count;
        while (items_sent < stop) begin
            if ($urandom_range(0, 9) == 0) begin
                send(byte_step(8'($urandom_range(0, 255)), 1'b0));
            end else begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 35)
                                                  : $urandom_range(0, int'(col_w) + 2);
                q = ($urandom_range(0, 3) == 0);
                if (q) send(byte_step(CH_QUOTE, 1'b0));
                for (int k = 0; k < len; k++) begin
                    ch = 8'($urandom_range(0, 255));
                    if (ch == CH_QUOTE || ch == CH_NEWLINE || (ch == CH_COMMA && !q))
                        ch = ch ^ 8'h40;
                    send(byte_step(ch, 1'b0));
                end
                if (q) send(byte_step(CH_QUOTE, 1'b0));
                pick = $urandom_range(0, 19);
                // leave the cell open now and then so that a width change lands mid-cell
                if (pick < 12)      send(byte_step(CH_COMMA, 1'b0));
                else if (pick < 17) send(byte_step(CH_NEWLINE, 1'b0));
            end
        end
    endtask

    always @(posedge aclk) begin : sink
        int n;
        if (hold > 0) begin
            hold <= hold - 1;
            if (hold == 1) m_tready <= 1'b1;
        end else if (m_tvalid && m_tready) begin
            n = sink_gaps ? $urandom_range(0, 8) : 0;
            if (n > 0) begin
                m_tready <= 1'b0;
                hold     <= n;
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_out
        col_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_in++;
            if (pending_out.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d unexpected: byte %h tok %b row %0d last %b",
                             results_in, m_tdata[7:0], m_tuser, m_tdata[23:8], m_tlast);
            end else begin
                want = pending_out.pop_front();
                if (m_tdata[7:0] !== want.ch || m_tuser !== want.tok ||
                    m_tdata[23:8] !== want.row || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: want byte %h tok %b row %0d last %b, got %h %b %0d %b",
                                 results_in, want.ch, want.tok, want.row, want.last,
                                 m_tdata[7:0], m_tuser, m_tdata[23:8], m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : main
        logic [4:0] w;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].reconf) begin
                wait_idle();
                set_config(DIRECTED[r].cw, DIRECTED[r].pc, DIRECTED[r].sri);
            end
            send(DIRECTED[r]);
        end

        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            case ($urandom_range(0, 5))
                0:       w = 5'd0;
                1:       w = 5'd31;
                2:       w = 5'd30;
                3:       w = 5'd1;
                default: w = 5'($urandom_range(2, 12));
            endcase
            set_config(w, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            // keep some phases free of idling on one side or the other
            send_gaps = (ph != 2);
            sink_gaps = (ph != 3) && (ph != 2);
            feed_rows(20);
            if ($urandom_range(0, 2) == 0) send(byte_step(8'($urandom_range(0, 255)), 1'b1));
        end

        // restart the stream and close a few rows with the index shown
        wait_idle();
        set_config(5'd3, 8'h2D, 1'b1);
        send(byte_step(8'h00, 1'b1));
        for (int k = 0; k < 4; k++) send(byte_step(CH_NEWLINE, 1'b0));
        send(byte_step(8'h5A, 1'b0));
        send(byte_step(8'h00, 1'b1));

        wait_idle();
        if (mismatches == 0 && pending_out.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/csvca_pkg.sv
hw/rtl/csvca_ctrl.sv
hw/rtl/csvca_datapath.sv
hw/rtl/csv_column_aligner.sv
hw/rtl/csvca_checker.sv
tb/tb_top.sv
